// ===== rtl/lsp_pkg.sv =====
// Package for the lattice stretch points block: widths, register indexes,
// opcodes, sequencer states and the divider handshake structs.
// Used by lsp_div and lattice_stretch_points_unit; depends on nothing.
package lsp_pkg;

  // Default values for the top level parameters.
  localparam int FRACTION_BITS_DEF = 16;
  localparam int COORD_BITS_DEF    = 16;

  // Fixed widths of the configuration port and of the result.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_W      = 16;
  localparam int POINT_W    = 32;
  localparam int OP_W       = 2;

  // The divider works on a 32 bit magnitude and a 16 bit divisor.
  localparam int DIV_W = 32;
  localparam int DEN_W = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_LENGTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALABLE_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_START    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_START    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_END      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SCALABLE  = 3'd5;

  // Input item opcodes.
  localparam logic [OP_W-1:0] OP_BEGIN    = 2'd0;
  localparam logic [OP_W-1:0] OP_DIVISION = 2'd1;
  localparam logic [OP_W-1:0] OP_END      = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_BEGIN,
    S_ACC,
    S_END
  } state_t;

  // Request and status between the sequencer and the divider.
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/lsp_div.sv =====
// Iterative restoring divider: one quotient bit per cycle.
// Depends on lsp_pkg for widths and the request and status structs.
module lsp_div (
  input  logic                     clk,
  input  logic                     rst,
  input  lsp_pkg::div_req_t        req,
  output lsp_pkg::div_stat_t       stat,
  output logic [lsp_pkg::DIV_W-1:0] quotient
);
  import lsp_pkg::*;

  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     rem_next;
  logic [DEN_W-1:0]     den;
  logic [DIV_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DEN_W:0]       shifted;
  logic                 q_bit;

  // One restoring step: shift in the next dividend bit and try to subtract.
  always_comb begin
    shifted = {rem, quo[DIV_W-1]};
    if (shifted >= {1'b0, den}) begin
      rem_next = DEN_W'(shifted - {1'b0, den});
      q_bit    = 1'b1;
    end else begin
      rem_next = shifted[DEN_W-1:0];
      q_bit    = 1'b0;
    end
  end

  // Control: busy from a start until the last quotient bit, then a one cycle done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out of quo as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      den <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIV_W-2:0], q_bit};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

// ===== rtl/lattice_stretch_points_unit.sv =====
// Lattice stretch points unit: maps lattice division coordinates onto a
// destination span in signed fixed point. Depends on lsp_pkg and lsp_div.
// A division or end item goes through S_ACC or S_END to the output register; a
// begin item first waits in S_DIV for the bit-serial divider computing the scale.
// One item is in work at a time; the output register lets the next item be taken
// while a result waits. Synchronous active high reset resets the configuration,
// sequencer, output valid and lattice state; no input is taken in reset.
module lattice_stretch_points_unit #(
  parameter int FRACTION_BITS = lsp_pkg::FRACTION_BITS_DEF,
  parameter int COORD_BITS    = lsp_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write port.
  input  logic                               wr_en,
  input  logic [lsp_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [lsp_pkg::CFG_DATA_W-1:0]     wr_data,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [((COORD_BITS+7)/8)*8-1:0]    s_tdata,  // division
  input  logic [lsp_pkg::OP_W-1:0]           s_tuser,  // opcode
  // Result stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lsp_pkg::POINT_W-1:0]        m_tdata,  // point
  output logic                               m_tlast,  // last_point
  output logic [0:0]                         m_tuser   // divisor_zero
);
  import lsp_pkg::*;

  localparam int FQ_W   = LEN_W + FRACTION_BITS;
  localparam int CMP_W  = ((FQ_W > POINT_W + 1) ? FQ_W : POINT_W + 1) + 1;
  localparam int DLT_W  = COORD_BITS + 1;
  localparam int PROD_W = POINT_W + DLT_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [POINT_W-1:0] ONE_Q = POINT_W'(1) << FRACTION_BITS;
  localparam logic signed [POINT_W-1:0] MAX_Q = {1'b0, {(POINT_W-1){1'b1}}};
  localparam logic signed [POINT_W-1:0] MIN_Q = {1'b1, {(POINT_W-1){1'b0}}};

  // Configuration registers.
  logic [LEN_W-1:0]          fixed_length;
  logic [LEN_W-1:0]          scalable_length;
  logic [LEN_W-1:0]          source_start;
  logic signed [POINT_W-1:0] target_start;
  logic signed [POINT_W-1:0] target_end;
  logic                      first_scalable;

  // Lattice state.
  logic signed [POINT_W-1:0] scale_scalable;
  logic signed [POINT_W-1:0] scale_fixed;
  logic [COORD_BITS-1:0]     prev_source;
  logic signed [POINT_W-1:0] running_point;
  logic                      seg_scalable;
  logic                      zero_seen;

  // Sequencer and work registers.
  state_t                    state;
  state_t                    state_next;
  logic                      normal;
  logic                      num_neg;
  logic                      den_zero;
  logic signed [PROD_W-1:0]  prod;

  // Output register.
  logic                      out_valid;
  logic signed [POINT_W-1:0] out_point;
  logic                      out_last;
  logic                      out_dz;

  // Combinational signals.
  logic                      accept;
  logic                      out_free;
  logic [OP_W-1:0]           opcode;
  logic [COORD_BITS-1:0]     division;
  logic signed [CMP_W-1:0]   len;
  logic signed [CMP_W-1:0]   fixed_q;
  logic signed [CMP_W-1:0]   num;
  logic                      normal_now;
  logic [DEN_W-1:0]          den_now;
  logic signed [DLT_W-1:0]   delta;
  logic signed [POINT_W-1:0] scale_sel;
  logic signed [PROD_W-1:0]  prod_next;
  logic signed [SUM_W-1:0]   sum;
  logic signed [POINT_W-1:0] sum_sat;
  logic signed [POINT_W:0]   q_signed;
  logic signed [POINT_W-1:0] scale_sat;
  logic                      load_begin;
  logic                      load_acc;
  logic                      load_end;
  div_req_t                  div_req;
  div_stat_t                 div_stat;
  logic [DIV_W-1:0]          div_quo;

  assign opcode   = s_tuser;
  assign division = s_tdata[COORD_BITS-1:0];
  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_length    <= '0;
      scalable_length <= LEN_W'(1);
      source_start    <= '0;
      target_start    <= '0;
      target_end      <= '0;
      first_scalable  <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_FIXED_LENGTH:    fixed_length    <= wr_data[LEN_W-1:0];
        REG_SCALABLE_LENGTH: scalable_length <= wr_data[LEN_W-1:0];
        REG_SOURCE_START:    source_start    <= wr_data[LEN_W-1:0];
        REG_TARGET_START:    target_start    <= wr_data[POINT_W-1:0];
        REG_TARGET_END:      target_end      <= wr_data[POINT_W-1:0];
        REG_FIRST_SCALABLE:  first_scalable  <= wr_data[0];
        default: ;
      endcase
    end
  end

  // Begin item: span length, mode choice and the numerator magnitude.
  // Both modes keep the numerator magnitude within 32 bits.
  always_comb begin
    len        = CMP_W'(target_end) - CMP_W'(target_start);
    fixed_q    = CMP_W'({fixed_length, {FRACTION_BITS{1'b0}}});
    normal_now = (fixed_q <= len);
    num        = normal_now ? (len - fixed_q) : len;
    den_now    = normal_now ? scalable_length : fixed_length;
    div_req.start    = accept && (opcode == OP_BEGIN);
    div_req.dividend = num[CMP_W-1] ? DIV_W'(-num) : DIV_W'(num);
    div_req.divisor  = den_now;
  end

  // Division item: signed source delta times the segment's scale.
  always_comb begin
    delta     = $signed({1'b0, division}) - $signed({1'b0, prev_source});
    scale_sel = seg_scalable ? scale_scalable : scale_fixed;
    prod_next = scale_sel * delta;
  end

  // Accumulate onto the running point and saturate to 32 bits.
  always_comb begin
    sum = SUM_W'(running_point) + SUM_W'(prod);
    if (sum[SUM_W-1:POINT_W-1] == '0 || sum[SUM_W-1:POINT_W-1] == '1) begin
      sum_sat = sum[POINT_W-1:0];
    end else begin
      sum_sat = sum[SUM_W-1] ? MIN_Q : MAX_Q;
    end
  end

  // Signed, saturated scale from the divider's magnitude quotient.
  always_comb begin
    q_signed = num_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    if (den_zero) begin
      scale_sat = '0;
    end else if (q_signed[POINT_W] != q_signed[POINT_W-1]) begin
      scale_sat = q_signed[POINT_W] ? MIN_Q : MAX_Q;
    end else begin
      scale_sat = q_signed[POINT_W-1:0];
    end
  end

  lsp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // Sequencer: next state, ready and the result load strobes.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_begin = 1'b0;
    load_acc   = 1'b0;
    load_end   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          case (opcode)
            OP_BEGIN:    state_next = S_DIV;
            OP_DIVISION: state_next = S_ACC;
            OP_END:      state_next = S_END;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_BEGIN;
        end
      end
      S_BEGIN: begin
        if (out_free) begin
          load_begin = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ACC: begin
        if (out_free) begin
          load_acc   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_END: begin
        if (out_free) begin
          load_end   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Work registers captured at the input transfer.
  always_ff @(posedge clk) begin
    if (div_req.start) begin
      normal   <= normal_now;
      num_neg  <= num[CMP_W-1];
      den_zero <= (den_now == '0);
    end
    if (accept && opcode == OP_DIVISION) begin
      prod <= prod_next;
    end
  end

  // Lattice state updates.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_scalable <= '0;
      scale_fixed    <= ONE_Q;
      prev_source    <= '0;
      running_point  <= '0;
      seg_scalable   <= 1'b0;
      zero_seen      <= 1'b0;
    end else begin
      if (accept && opcode == OP_DIVISION) begin
        prev_source  <= division;
        seg_scalable <= !seg_scalable;
      end
      if (load_acc) begin
        running_point <= sum_sat;
      end
      if (load_begin) begin
        scale_scalable <= normal ? scale_sat : '0;
        scale_fixed    <= normal ? ONE_Q : scale_sat;
        prev_source    <= COORD_BITS'(source_start);
        running_point  <= target_start;
        seg_scalable   <= first_scalable;
        zero_seen      <= den_zero;
      end
    end
  end

  // Output register: valid until the result transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_begin || load_acc || load_end) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_begin) begin
      out_point <= target_start;
      out_last  <= 1'b0;
      out_dz    <= den_zero;
    end else if (load_acc) begin
      out_point <= sum_sat;
      out_last  <= 1'b0;
      out_dz    <= zero_seen;
    end else if (load_end) begin
      out_point <= target_end;
      out_last  <= 1'b1;
      out_dz    <= zero_seen;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_point;
  assign m_tlast    = out_last;
  assign m_tuser[0] = out_dz;

`ifndef SYNTHESIS
  // The input side is never open while the divider is still iterating.
  a_ready_not_dividing: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_stat.busy)
    else $error("input ready while the divider is busy");

  // A divider completion only arrives while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider done outside the divide state");

  // Fixed segments only lose unit scale in shrink mode, where scalable ones are zero.
  a_shrink_scales: assert property (@(posedge clk) disable iff (rst)
    (scale_fixed != ONE_Q) |-> (scale_scalable == '0))
    else $error("shrink mode with a nonzero scalable scale");
`endif

endmodule
